// ===== rtl/core/tide_pkg.sv =====
// Shared opcodes, flag bit positions and the response layout for the
// toy ISA decode/execute block. No dependencies.
`default_nettype none

package tide_pkg;

   // Instruction opcodes (bits 31:26); anything above OPC_BR is illegal
   localparam logic [5:0] OPC_LDI = 6'd0;
   localparam logic [5:0] OPC_LDW = 6'd1;
   localparam logic [5:0] OPC_STW = 6'd2;
   localparam logic [5:0] OPC_ADD = 6'd3;
   localparam logic [5:0] OPC_SLL = 6'd4;
   localparam logic [5:0] OPC_NEG = 6'd5;
   localparam logic [5:0] OPC_HLT = 6'd6;
   localparam logic [5:0] OPC_TST = 6'd7;
   localparam logic [5:0] OPC_CMP = 6'd8;
   localparam logic [5:0] OPC_BR  = 6'd9;

   // Flag bit positions written by tst and cmp
   localparam int FLAG_ZERO = 1;
   localparam int FLAG_EQ   = 2;
   localparam int FLAG_GT   = 3;
   localparam int FLAG_LT   = 4;
   localparam int FLAG_POS  = 8;
   localparam int FLAG_NPOS = 9;

   localparam int REG_ADDR_BITS = 5;
   localparam int REG_COUNT     = 32;
   localparam int RSP_PAD_BITS  = 5;

   // Response layout, lowest field last
   typedef struct packed {
      logic [31:0] executed_count;
      logic        illegal_opcode;
      logic        halted;
      logic [31:0] store_value;
      logic        store_valid;
      logic [31:0] next_pc;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/tide_ram.sv =====
// Generic synchronous RAM: one write port, two registered read ports
// with a shared read enable; read during write returns the old data.
`default_nettype none

module tide_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AddrW-1:0] waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AddrW-1:0] raddr_a,
   input  wire logic [AddrW-1:0] raddr_b,
   output logic      [WIDTH-1:0] rdata_a,
   output logic      [WIDTH-1:0] rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff, rdata_b_ff;

   // Write the entry
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Register both reads; hold data while re is low
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_a_ff <= mem_ff[raddr_a];
         rdata_b_ff <= mem_ff[raddr_b];
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

`default_nettype wire

// ===== rtl/core/toy_isa_decode_execute_top.sv =====
// Toy ISA decode/execute top level: register file and byte-lane data
// memory in tide_ram instances. Depends on tide_pkg and tide_ram.
// A request passes through the execute register and then the output register;
// ldw also goes through a write-back stage that reads the data memory.
// Throughput: one request per cycle while the output is not stalled; an
// ldw holds execute until its data memory read and register write-back are done.
// Reset clears control, PC, count, halt state and register valid bits;
// the data memory is not cleared and no clearing pass runs.
`default_nettype none

module toy_isa_decode_execute_top #(
   parameter int MEM_ADDR_BITS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // [31:0] instruction_word
   input  wire logic [31:0]  req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [31:0] next_pc, [32] store_valid, [64:33] store_value, [65] halted,
   // [66] illegal_opcode, [98:67] executed_count, [103:99] zero
   output logic [103:0]      rsp_tdata
);

   import tide_pkg::*;

   localparam int RowBits = MEM_ADDR_BITS - 2;
   localparam int Rows    = 1 << RowBits;

   // Pipeline control
   logic        e_valid_ff, e_valid_in;
   logic        w_valid_ff, w_valid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic [31:0] inst_ff;
   logic        req_accept, out_free, e_go, w_done;

   // Architectural state kept in flops
   logic [31:0] pc_ff, pc_in;
   logic [31:0] count_ff, count_in;
   logic        stopped_ff, stopped_in;
   logic [REG_COUNT-1:0] rf_valid_ff, rf_valid_in;

   // Last register write, for forwarding over the RAM read
   logic                     fwd_valid_ff;
   logic [REG_ADDR_BITS-1:0] fwd_addr_ff;
   logic [31:0]              fwd_data_ff;

   // Load write-back stage
   rsp_type                  w_rsp_ff;
   logic [REG_ADDR_BITS-1:0] w_dest_ff;
   logic [1:0]               w_lane_ff;

   // Register file ports
   logic                     rf_we;
   logic [REG_ADDR_BITS-1:0] rf_waddr, rf_raddr_a, rf_raddr_b;
   logic [31:0]              rf_wdata, rf_rdata_a, rf_rdata_b;

   // Execute decode
   logic [5:0]               opc_e;
   logic [REG_ADDR_BITS-1:0] op1_e, op2_e, op3_e, rb_e;
   logic [4:0]               shf_e;
   logic [15:0]              imm_e;
   logic [31:0]              a_val, b_val;
   logic                     is_load_e, is_store_e;
   logic                     e_wr;
   logic [31:0]              e_wdata;
   rsp_type                  e_rsp;

   // Data memory
   logic [MEM_ADDR_BITS-1:0] maddr_e;
   logic [1:0]               lane_e;
   logic [7:0]               bank_rdata [4];
   logic [31:0]              load_word;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !e_valid_ff || e_go;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_BITS{1'b0}}, rsp_ff};

   // Issue register reads straight from the request
   always_comb begin
      rf_raddr_a = req_tdata[20:16];
      if (req_tdata[31:26] == OPC_ADD || req_tdata[31:26] == OPC_CMP) begin
         rf_raddr_b = req_tdata[15:11];
      end else begin
         rf_raddr_b = req_tdata[25:21];
      end
   end

   // Decode the instruction in execute
   assign opc_e = inst_ff[31:26];
   assign op1_e = inst_ff[25:21];
   assign op2_e = inst_ff[20:16];
   assign op3_e = inst_ff[15:11];
   assign shf_e = inst_ff[10:6];
   assign imm_e = inst_ff[15:0];
   assign rb_e  = (opc_e == OPC_ADD || opc_e == OPC_CMP) ? op3_e : op1_e;

   // Resolve operands: forwarded write, then RAM, unwritten reads as zero
   always_comb begin
      if (fwd_valid_ff && fwd_addr_ff == op2_e) begin
         a_val = fwd_data_ff;
      end else if (rf_valid_ff[op2_e]) begin
         a_val = rf_rdata_a;
      end else begin
         a_val = '0;
      end
      if (fwd_valid_ff && fwd_addr_ff == rb_e) begin
         b_val = fwd_data_ff;
      end else if (rf_valid_ff[rb_e]) begin
         b_val = rf_rdata_b;
      end else begin
         b_val = '0;
      end
   end

   assign is_load_e  = !stopped_ff && opc_e == OPC_LDW;
   assign is_store_e = !stopped_ff && opc_e == OPC_STW;

   // Execute: new PC, count, halt state, register write and response
   always_comb begin
      e_wr                  = 1'b0;
      e_wdata               = '0;
      e_rsp.store_valid     = 1'b0;
      e_rsp.store_value     = '0;
      e_rsp.illegal_opcode  = 1'b0;
      pc_in                 = pc_ff;
      stopped_in            = stopped_ff;
      count_in              = count_ff;
      if (!stopped_ff) begin
         count_in = count_ff + 32'd1;
         pc_in    = pc_ff + 32'd4;
         case (opc_e)
            OPC_LDI: begin
               e_wr    = 1'b1;
               e_wdata = {16'd0, imm_e};
            end
            OPC_LDW: begin
               e_wr = 1'b0;
            end
            OPC_STW: begin
               e_rsp.store_valid = 1'b1;
               e_rsp.store_value = a_val;
            end
            OPC_ADD: begin
               e_wr    = 1'b1;
               e_wdata = a_val + b_val;
            end
            OPC_SLL: begin
               e_wr    = 1'b1;
               e_wdata = a_val << shf_e;
            end
            OPC_NEG: begin
               e_wr    = 1'b1;
               e_wdata = 32'd0 - a_val;
            end
            OPC_HLT: begin
               stopped_in = 1'b1;
            end
            OPC_TST: begin
               e_wr = 1'b1;
               e_wdata[FLAG_ZERO] = (a_val == 32'd0);
               e_wdata[FLAG_POS]  = ($signed(a_val) > 32'sd0);
               e_wdata[FLAG_NPOS] = !($signed(a_val) > 32'sd0);
            end
            OPC_CMP: begin
               e_wr = 1'b1;
               e_wdata[FLAG_EQ] = (a_val == b_val);
               e_wdata[FLAG_GT] = ($signed(a_val) > $signed(b_val));
               e_wdata[FLAG_LT] = ($signed(a_val) < $signed(b_val));
            end
            OPC_BR: begin
               if (op2_e == '0 || b_val[op2_e]) begin
                  pc_in = pc_ff + {{14{imm_e[15]}}, imm_e, 2'b00};
               end
            end
            default: begin
               e_rsp.illegal_opcode = 1'b1;
               stopped_in           = 1'b1;
               pc_in                = pc_ff;
            end
         endcase
      end
      e_rsp.next_pc        = pc_in;
      e_rsp.halted         = stopped_in;
      e_rsp.executed_count = count_in;
   end

   // Advance execute once the load stage is empty and, unless loading, output is free
   assign e_go   = e_valid_ff && !w_valid_ff && (is_load_e || out_free);
   assign w_done = w_valid_ff && out_free;

   // Register write: load write-back or execute result
   always_comb begin
      if (w_done) begin
         rf_we    = 1'b1;
         rf_waddr = w_dest_ff;
         rf_wdata = load_word;
      end else begin
         rf_we    = e_go && e_wr;
         rf_waddr = op1_e;
         rf_wdata = e_wdata;
      end
   end

   always_comb begin
      rf_valid_in = rf_valid_ff;
      if (rf_we) begin
         rf_valid_in[rf_waddr] = 1'b1;
      end
   end

   tide_ram #(
      .WIDTH (32),
      .DEPTH (REG_COUNT)
   ) u_regfile (
      .clock   (clock),
      .we      (rf_we),
      .waddr   (rf_waddr),
      .wdata   (rf_wdata),
      .re      (req_accept),
      .raddr_a (rf_raddr_a),
      .raddr_b (rf_raddr_b),
      .rdata_a (rf_rdata_a),
      .rdata_b (rf_rdata_b)
   );

   // Data memory: four byte lanes, word may straddle rows and wraps
   always_comb begin
      if (is_store_e) begin
         maddr_e = b_val[MEM_ADDR_BITS-1:0];
      end else begin
         maddr_e = a_val[MEM_ADDR_BITS-1:0];
      end
   end
   assign lane_e = maddr_e[1:0];

   for (genvar k = 0; k < 4; k++) begin : g_bank
      logic [1:0]         off;
      logic [RowBits-1:0] row;
      logic [31:0]        shifted;

      assign off     = 2'(k) - lane_e;
      assign row     = maddr_e[MEM_ADDR_BITS-1:2] + RowBits'(2'(k) < lane_e);
      assign shifted = a_val >> {off, 3'b000};

      tide_ram #(
         .WIDTH (8),
         .DEPTH (Rows)
      ) u_bank (
         .clock   (clock),
         .we      (e_go && is_store_e),
         .waddr   (row),
         .wdata   (shifted[7:0]),
         .re      (e_go && is_load_e),
         .raddr_a (row),
         .raddr_b (row),
         .rdata_a (bank_rdata[k]),
         .rdata_b ()
      );
   end

   // Gather the loaded word, lowest byte from the starting lane
   always_comb begin
      load_word = {bank_rdata[w_lane_ff + 2'd3], bank_rdata[w_lane_ff + 2'd2],
                   bank_rdata[w_lane_ff + 2'd1], bank_rdata[w_lane_ff]};
   end

   // Stage valids and the output register
   always_comb begin
      e_valid_in = req_accept || (e_valid_ff && !e_go);
      w_valid_in = (e_go && is_load_e) || (w_valid_ff && !w_done);
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      if (w_done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = w_rsp_ff;
      end else if (e_go && !is_load_e) begin
         rsp_valid_in = 1'b1;
         rsp_in       = e_rsp;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff   <= 1'b0;
         w_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= '0;
         count_ff     <= '0;
         stopped_ff   <= 1'b0;
         rf_valid_ff  <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         e_valid_ff   <= e_valid_in;
         w_valid_ff   <= w_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rf_valid_ff  <= rf_valid_in;
         if (e_go) begin
            pc_ff      <= pc_in;
            count_ff   <= count_in;
            stopped_ff <= stopped_in;
         end
         if (rf_we) begin
            fwd_valid_ff <= 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (req_accept) begin
         inst_ff <= req_tdata;
      end
      if (rf_we) begin
         fwd_addr_ff <= rf_waddr;
         fwd_data_ff <= rf_wdata;
      end
      if (e_go && is_load_e) begin
         w_rsp_ff  <= e_rsp;
         w_dest_ff <= op1_e;
         w_lane_ff <= lane_e;
      end
   end

endmodule

`default_nettype wire
